// ===== hdl/co2_uart_reply_frame_checker_top_macros.svh =====
// Assertion macros for the CO2 reply frame checker.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef CO2_UART_REPLY_FRAME_CHECKER_TOP_MACROS_SVH
`define CO2_UART_REPLY_FRAME_CHECKER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define CO2RFC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("co2rfc assertion failed");

// next-cycle implication, checked out of reset
`define CO2RFC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("co2rfc assertion failed");

`endif

// ===== hdl/co2rfc_pkg.sv =====
// Package for the CO2 reply frame checker: item codes, status codes,
// frame constants and the result type. No dependencies.
`default_nettype none

package co2rfc_pkg;

	// item kinds
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// result status
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TIMEOUT  = 3'd1;
	localparam logic [2:0] ST_HEADER   = 3'd2;
	localparam logic [2:0] ST_LENCMD   = 3'd3;
	localparam logic [2:0] ST_CHECKSUM = 3'd4;

	// register indexes
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_PREHEAT = 1'b1;

	// frame bytes
	localparam logic [7:0] HEAD_BYTE = 8'hFE;
	localparam logic [7:0] CODE_BYTE = 8'hA6;
	localparam logic [7:0] LEN_BYTE  = 8'h04;
	localparam logic [7:0] CMD_BYTE  = 8'h01;

	localparam logic [3:0] POS_HEAD    = 4'd0;
	localparam logic [3:0] POS_CODE    = 4'd1;
	localparam logic [3:0] POS_LEN     = 4'd2;
	localparam logic [3:0] POS_CMD     = 4'd3;
	localparam logic [3:0] POS_PPM_HI  = 4'd4;
	localparam logic [3:0] POS_PPM_LO  = 4'd5;
	localparam logic [3:0] POS_SUM_END = 4'd7;
	localparam logic [3:0] POS_LAST    = 4'd8;
	localparam logic [3:0] FRAME_BYTES = 4'd9;

	localparam logic [15:0] TIMEOUT_RESET = 16'd200;
	localparam logic [16:0] PREHEAT_RESET = 17'd120000;
	localparam logic [15:0] WAIT_MAX      = 16'hFFFF;

	typedef struct packed {
		logic [15:0] co2_ppm;
		logic        reading_ok;
		logic [2:0]  status;
		logic        preheating;
		logic [3:0]  bytes_received;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/co2_uart_reply_frame_checker_top.sv =====
// CO2 reply frame checker: an accepted input beat passes through the input register and then
// the result register before its result, if it makes one, is valid at the outputs.
// Throughput one item per cycle; the input stalls only while both the result register
// and its skid stage are full. Reset (arst_n low, asynchronous) disarms the read, clears
// frame progress and uptime, and loads a 200 ms timeout and a 120000 ms preheat limit.
// Depends on co2rfc_pkg and co2_uart_reply_frame_checker_top_macros.svh.
`default_nettype none
`include "co2_uart_reply_frame_checker_top_macros.svh"

module co2_uart_reply_frame_checker_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  rx_byte,
	// results
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      co2_ppm,
	output logic             reading_ok,
	output logic [2:0]       status,
	output logic             preheating,
	output logic [3:0]       bytes_received,
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [16:0] cfg_data
);

	// configuration
	logic [15:0] timeout_q;
	logic [16:0] preheat_q;

	// input stage
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [7:0] byte_s1;

	// frame state
	logic        collecting_q;
	logic [3:0]  byte_count_q;
	logic        hdr_err_q;
	logic        lencmd_err_q;
	logic [7:0]  sum_q;
	logic [7:0]  ppm_hi_q;
	logic [7:0]  ppm_lo_q;
	logic [15:0] wait_q;
	logic [16:0] uptime_q;

	// result register and skid
	logic                 out_valid_q;
	logic                 skid_valid_q;
	co2rfc_pkg::result_t  out_q;
	co2rfc_pkg::result_t  skid_q;

	// next-state logic
	logic                 proc;
	logic                 in_acc;
	logic                 out_pop;
	logic                 res_vld;
	co2rfc_pkg::result_t  res;
	logic                 collecting_d;
	logic [3:0]           byte_count_d;
	logic                 hdr_err_d;
	logic                 lencmd_err_d;
	logic [7:0]           sum_d;
	logic [7:0]           ppm_hi_d;
	logic [7:0]           ppm_lo_d;
	logic [15:0]          wait_d;
	logic [16:0]          uptime_d;
	logic [2:0]           st;

	assign proc      = valid_s1 && !skid_valid_q;
	assign in_stall  = valid_s1 && skid_valid_q;
	assign in_acc    = in_valid && !in_stall;
	assign out_pop   = out_valid_q && !out_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		collecting_d = collecting_q;
		byte_count_d = byte_count_q;
		hdr_err_d    = hdr_err_q;
		lencmd_err_d = lencmd_err_q;
		sum_d        = sum_q;
		ppm_hi_d     = ppm_hi_q;
		ppm_lo_d     = ppm_lo_q;
		wait_d       = wait_q;
		uptime_d     = uptime_q;
		res_vld      = 1'b0;
		st           = co2rfc_pkg::ST_OK;

		case (op_s1)
			co2rfc_pkg::OP_START: begin
				collecting_d = 1'b1;
				byte_count_d = '0;
				hdr_err_d    = 1'b0;
				lencmd_err_d = 1'b0;
				sum_d        = '0;
				ppm_hi_d     = '0;
				ppm_lo_d     = '0;
				wait_d       = '0;
			end
			co2rfc_pkg::OP_BYTE: begin
				if (collecting_q) begin
					if ((byte_count_q == co2rfc_pkg::POS_HEAD && byte_s1 != co2rfc_pkg::HEAD_BYTE) ||
					    (byte_count_q == co2rfc_pkg::POS_CODE && byte_s1 != co2rfc_pkg::CODE_BYTE))
						hdr_err_d = 1'b1;
					if ((byte_count_q == co2rfc_pkg::POS_LEN && byte_s1 != co2rfc_pkg::LEN_BYTE) ||
					    (byte_count_q == co2rfc_pkg::POS_CMD && byte_s1 != co2rfc_pkg::CMD_BYTE))
						lencmd_err_d = 1'b1;
					if (byte_count_q == co2rfc_pkg::POS_PPM_HI)
						ppm_hi_d = byte_s1;
					if (byte_count_q == co2rfc_pkg::POS_PPM_LO)
						ppm_lo_d = byte_s1;
					if (byte_count_q >= co2rfc_pkg::POS_CODE &&
					    byte_count_q <= co2rfc_pkg::POS_SUM_END)
						sum_d = sum_q + byte_s1;
					byte_count_d = byte_count_q + 4'd1;
					if (byte_count_q >= co2rfc_pkg::POS_LAST) begin
						// ninth byte is the checksum itself; error priority as listed
						collecting_d = 1'b0;
						res_vld      = 1'b1;
						if (hdr_err_q)
							st = co2rfc_pkg::ST_HEADER;
						else if (lencmd_err_q)
							st = co2rfc_pkg::ST_LENCMD;
						else if (sum_q != byte_s1)
							st = co2rfc_pkg::ST_CHECKSUM;
						else
							st = co2rfc_pkg::ST_OK;
					end
				end
			end
			co2rfc_pkg::OP_TICK: begin
				if (uptime_q < preheat_q)
					uptime_d = uptime_q + 17'd1;
				if (collecting_q) begin
					if (wait_q < co2rfc_pkg::WAIT_MAX)
						wait_d = wait_q + 16'd1;
					if (wait_d >= timeout_q) begin
						collecting_d = 1'b0;
						res_vld      = 1'b1;
						st           = co2rfc_pkg::ST_TIMEOUT;
					end
				end
			end
			default: begin
			end
		endcase

		res.status         = st;
		res.reading_ok     = (st == co2rfc_pkg::ST_OK);
		res.co2_ppm        = (st == co2rfc_pkg::ST_OK) ? {ppm_hi_d, ppm_lo_d} : 16'd0;
		res.preheating     = (uptime_d < preheat_q);
		res.bytes_received = byte_count_d;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= co2rfc_pkg::TIMEOUT_RESET;
			preheat_q <= co2rfc_pkg::PREHEAT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				co2rfc_pkg::REG_TIMEOUT: timeout_q <= cfg_data[15:0];
				co2rfc_pkg::REG_PREHEAT: preheat_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= op;
			byte_s1 <= rx_byte;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			byte_count_q <= '0;
			hdr_err_q    <= 1'b0;
			lencmd_err_q <= 1'b0;
			sum_q        <= '0;
			ppm_hi_q     <= '0;
			ppm_lo_q     <= '0;
			wait_q       <= '0;
			uptime_q     <= '0;
		end else if (proc) begin
			collecting_q <= collecting_d;
			byte_count_q <= byte_count_d;
			hdr_err_q    <= hdr_err_d;
			lencmd_err_q <= lencmd_err_d;
			sum_q        <= sum_d;
			ppm_hi_q     <= ppm_hi_d;
			ppm_lo_q     <= ppm_lo_d;
			wait_q       <= wait_d;
			uptime_q     <= uptime_d;
		end
	end

	// result register with skid stage; a new result only arrives while skid is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_pop || !out_valid_q) begin
				out_valid_q  <= skid_valid_q || (proc && res_vld);
				skid_valid_q <= 1'b0;
			end else if (proc && res_vld) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_pop || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (proc && res_vld) begin
			skid_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign co2_ppm        = out_q.co2_ppm;
	assign reading_ok     = out_q.reading_ok;
	assign status         = out_q.status;
	assign preheating     = out_q.preheating;
	assign bytes_received = out_q.bytes_received;

	`CO2RFC_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
	`CO2RFC_ASSERT_NOW(a_ok_full_frame, out_valid && status == co2rfc_pkg::ST_OK,
		reading_ok && bytes_received == co2rfc_pkg::FRAME_BYTES)
	`CO2RFC_ASSERT_NOW(a_bad_no_ppm, out_valid && status != co2rfc_pkg::ST_OK,
		co2_ppm == 16'd0 && !reading_ok)
	`CO2RFC_ASSERT_NOW(a_count_in_frame, collecting_q, byte_count_q <= co2rfc_pkg::POS_LAST)
	`CO2RFC_ASSERT_NEXT(a_frame_end_disarms, proc && res_vld, !collecting_q)

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for co2_uart_reply_frame_checker_top: directed and random sensor reply frames,
// millisecond ticks and register writes, checked beat by beat against an in-file model.
// Depends on co2rfc_pkg and the RTL top module; needs nothing else.

module tb_top;

	// op value the block has no use for
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum int {FR_GOOD, FR_HEADER, FR_LENCMD, FR_CHECKSUM, FR_MIXED, FR_SHORT} frame_kind_t;

	// Tracks the frame checker state and holds the readings it owes.
	class reply_check_t;
		bit [15:0] timeout_ms;
		bit [16:0] preheat_limit;
		bit        armed;
		bit [3:0]  nbytes;
		bit        hdr_err;
		bit        lc_err;
		bit [7:0]  sum;
		bit [7:0]  ppm_hi;
		bit [7:0]  ppm_lo;
		bit [15:0] waited;
		bit [16:0] uptime;
		co2rfc_pkg::result_t owed_readings[$];
		int        errors;

		function new();
			timeout_ms = co2rfc_pkg::TIMEOUT_RESET;
			preheat_limit = co2rfc_pkg::PREHEAT_RESET;
			armed = 1'b0;
			uptime = '0;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			nbytes = '0;
			hdr_err = 1'b0;
			lc_err = 1'b0;
			sum = '0;
			ppm_hi = '0;
			ppm_lo = '0;
			waited = '0;
		endfunction

		function int pending();
			return owed_readings.size();
		endfunction

		function void write_register(logic idx, logic [16:0] data);
			if (idx == co2rfc_pkg::REG_TIMEOUT)
				timeout_ms = data[15:0];
			else
				preheat_limit = data;
		endfunction

		function void emit(logic [2:0] st);
			co2rfc_pkg::result_t r;
			r.co2_ppm = (st == co2rfc_pkg::ST_OK) ? {ppm_hi, ppm_lo} : 16'd0;
			r.reading_ok = (st == co2rfc_pkg::ST_OK);
			r.status = st;
			r.preheating = (uptime < preheat_limit);
			r.bytes_received = nbytes;
			owed_readings.push_back(r);
		endfunction

		// called for every accepted input beat
		function void take_item(logic [1:0] kind, logic [7:0] b);
			logic [3:0] pos;
			pos = nbytes;
			case (kind)
			co2rfc_pkg::OP_START: begin
				armed = 1'b1;
				clear_frame();
			end
			co2rfc_pkg::OP_BYTE: begin
				if (armed) begin
					if (pos == co2rfc_pkg::POS_HEAD && b != co2rfc_pkg::HEAD_BYTE) hdr_err = 1'b1;
					if (pos == co2rfc_pkg::POS_CODE && b != co2rfc_pkg::CODE_BYTE) hdr_err = 1'b1;
					if (pos == co2rfc_pkg::POS_LEN && b != co2rfc_pkg::LEN_BYTE) lc_err = 1'b1;
					if (pos == co2rfc_pkg::POS_CMD && b != co2rfc_pkg::CMD_BYTE) lc_err = 1'b1;
					if (pos == co2rfc_pkg::POS_PPM_HI) ppm_hi = b;
					if (pos == co2rfc_pkg::POS_PPM_LO) ppm_lo = b;
					if (pos >= co2rfc_pkg::POS_CODE && pos <= co2rfc_pkg::POS_SUM_END)
						sum = sum + b;
					nbytes = pos + 4'd1;
					if (pos == co2rfc_pkg::POS_LAST) begin
						armed = 1'b0;
						if (hdr_err)
							emit(co2rfc_pkg::ST_HEADER);
						else if (lc_err)
							emit(co2rfc_pkg::ST_LENCMD);
						else if (sum != b)
							emit(co2rfc_pkg::ST_CHECKSUM);
						else
							emit(co2rfc_pkg::ST_OK);
					end
				end
			end
			co2rfc_pkg::OP_TICK: begin
				if (uptime < preheat_limit) uptime = uptime + 17'd1;
				if (armed) begin
					if (waited != co2rfc_pkg::WAIT_MAX) waited = waited + 16'd1;
					if (waited >= timeout_ms) begin
						armed = 1'b0;
						emit(co2rfc_pkg::ST_TIMEOUT);
					end
				end
			end
			default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [16:0] want, logic [16:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// called for every accepted result beat
		function void check_reading(co2rfc_pkg::result_t got);
			co2rfc_pkg::result_t want;
			if (owed_readings.size() == 0) begin
				$display("%0t: unexpected reading, expected none, got status %0d ppm %0d",
					$time, got.status, got.co2_ppm);
				errors++;
				return;
			end
			want = owed_readings.pop_front();
			compare_field("co2_ppm", 17'(want.co2_ppm), 17'(got.co2_ppm));
			compare_field("reading_ok", 17'(want.reading_ok), 17'(got.reading_ok));
			compare_field("status", 17'(want.status), 17'(got.status));
			compare_field("preheating", 17'(want.preheating), 17'(got.preheating));
			compare_field("bytes_received", 17'(want.bytes_received),
				17'(got.bytes_received));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	wire         in_stall;
	logic [1:0]  op = co2rfc_pkg::OP_START;
	logic [7:0]  rx_byte = 8'd0;
	wire         out_valid;
	logic        out_stall = 1'b0;
	wire  [15:0] co2_ppm;
	wire         reading_ok;
	wire  [2:0]  status;
	wire         preheating;
	wire  [3:0]  bytes_received;
	logic        cfg_valid = 1'b0;
	wire         cfg_ready;
	logic        cfg_index = co2rfc_pkg::REG_TIMEOUT;
	logic [16:0] cfg_data = 17'd0;

	int send_gap_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int items_sent = 0;
	reply_check_t model;

	co2_uart_reply_frame_checker_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.co2_ppm(co2_ppm),
		.reading_ok(reading_ok),
		.status(status),
		.preheating(preheating),
		.bytes_received(bytes_received),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// receiver: long hold-off when asked, random stalls otherwise
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			model.check_reading('{co2_ppm, reading_ok, status, preheating, bytes_received});
	end

	task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		model.take_item(kind, b);
		items_sent++;
		@(negedge clk);
	endtask

	// payload holds frame bytes 4..7, most significant first
	task automatic send_frame(input frame_kind_t kind, input int tick_pct, input logic [31:0] payload);
		logic [7:0] fr [9];
		logic [7:0] s;
		int i;
		int n;
		fr[0] = co2rfc_pkg::HEAD_BYTE;
		fr[1] = co2rfc_pkg::CODE_BYTE;
		fr[2] = co2rfc_pkg::LEN_BYTE;
		fr[3] = co2rfc_pkg::CMD_BYTE;
		for (i = 0; i < 4; i++) fr[4 + i] = payload[31 - 8 * i -: 8];
		s = '0;
		for (i = 1; i < 8; i++) s = s + fr[i];
		fr[8] = s;
		n = 9;
		case (kind)
		FR_HEADER: fr[$urandom_range(1)] ^= 8'($urandom_range(1, 255));
		FR_LENCMD: fr[$urandom_range(2, 3)] ^= 8'($urandom_range(1, 255));
		FR_CHECKSUM: fr[8] ^= 8'($urandom_range(1, 255));
		FR_MIXED: begin
			if ($urandom_range(1)) fr[$urandom_range(1)] ^= 8'($urandom_range(1, 255));
			if ($urandom_range(1)) fr[$urandom_range(2, 3)] ^= 8'($urandom_range(1, 255));
			if ($urandom_range(1)) fr[8] ^= 8'($urandom_range(1, 255));
		end
		FR_SHORT: n = $urandom_range(0, 8);
		default: ;
		endcase
		send_item(co2rfc_pkg::OP_START, 8'($urandom_range(255)));
		for (i = 0; i < n; i++) begin
			if ($urandom_range(99) < tick_pct)
				send_item(co2rfc_pkg::OP_TICK, 8'($urandom_range(255)));
			send_item(co2rfc_pkg::OP_BYTE, fr[i]);
		end
		// a cut-off reply waits for its timeout, or is dropped by the next start
		if (kind == FR_SHORT)
			repeat ($urandom_range(0, 40))
				send_item(co2rfc_pkg::OP_TICK, 8'($urandom_range(255)));
	endtask

	task automatic run_phase(input int n, input int tick_pct);
		int stop_at;
		int pick;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(9);
			case (pick)
			0: repeat ($urandom_range(1, 3))
				send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
			1: send_frame(FR_SHORT, tick_pct, $urandom());
			2: send_frame(FR_HEADER, tick_pct, $urandom());
			3: send_frame(FR_LENCMD, tick_pct, $urandom());
			4: send_frame(FR_CHECKSUM, tick_pct, $urandom());
			5: send_frame(FR_MIXED, tick_pct, $urandom());
			default: send_frame(FR_GOOD, tick_pct, $urandom());
			endcase
		end
	endtask

	// only with the block drained; bit 16 of the timeout write is junk the block drops
	task automatic write_registers(input logic [15:0] tmo, input logic [16:0] pre);
		logic [16:0] data;
		in_valid <= 1'b0;
		while (model.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		data = {1'($urandom_range(1)), tmo};
		cfg_valid <= 1'b1;
		cfg_index <= co2rfc_pkg::REG_TIMEOUT;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		model.write_register(co2rfc_pkg::REG_TIMEOUT, data);
		@(negedge clk);
		cfg_index <= co2rfc_pkg::REG_PREHEAT;
		cfg_data <= pre;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		model.write_register(co2rfc_pkg::REG_PREHEAT, pre);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		model = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: stray beats, restart while armed, extreme ppm values
		send_item(co2rfc_pkg::OP_BYTE, 8'hFF);
		send_item(OP_UNUSED, 8'h00);
		send_item(co2rfc_pkg::OP_TICK, 8'h00);
		send_item(co2rfc_pkg::OP_START, 8'hFF);
		send_item(co2rfc_pkg::OP_BYTE, co2rfc_pkg::HEAD_BYTE);
		send_frame(FR_GOOD, 0, 32'hFFFF_00FF);
		send_frame(FR_GOOD, 0, 32'h0000_0000);

		// zero timeout fires on the first tick; later bytes are ignored
		write_registers(16'd0, 17'd5);
		send_item(co2rfc_pkg::OP_START, 8'h00);
		send_item(co2rfc_pkg::OP_TICK, 8'hFF);
		send_item(co2rfc_pkg::OP_BYTE, co2rfc_pkg::HEAD_BYTE);

		write_registers(16'd7, 17'd60);
		send_gap_pct = 0;
		stall_pct = 0;
		run_phase(200, 15);

		write_registers(16'd1, 17'd0);
		send_gap_pct = 62;
		stall_pct = 0;
		run_phase(200, 5);

		write_registers(16'hFFFF, 17'h1FFFF);
		send_gap_pct = 0;
		stall_pct = 62;
		run_phase(200, 15);

		write_registers(16'd20, 17'($urandom_range(0, 400)));
		send_gap_pct = 30;
		stall_pct = 30;
		run_phase(200, 25);

		// receiver holds off while the sender keeps pushing
		write_registers(16'd3, 17'($urandom_range(131071)));
		send_gap_pct = 0;
		stall_pct = 0;
		hold_left <= 150;
		run_phase(200, 15);

		write_registers(16'($urandom_range(1, 40)), 17'($urandom_range(0, 3000)));
		send_gap_pct = 30;
		stall_pct = 30;
		run_phase(200, 15);

		in_valid <= 1'b0;
		while (model.pending() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (model.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_top failed");
		$finish;
	end

endmodule
